[rtl/ntc_pkg.sv]
package ntc_pkg;

  // Register map, one word per register
  typedef enum logic [1:0] {
    REG_SERIES = 2'd0,
    REG_R0     = 2'd1,
    REG_BETA   = 2'd2,
    REG_T0     = 2'd3
  } ntc_reg_t;

  localparam logic [19:0] SERIES_RESET = 20'd10000;
  localparam logic [19:0] R0_RESET     = 20'd10000;
  localparam logic [13:0] BETA_RESET   = 14'd3900;
  localparam logic [8:0]  T0_RESET     = 9'd25;

  // ln(2) in Q32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  // 273.15 K in Q16, 0 C in centikelvin, 40 K in Q16
  localparam logic [24:0] KELVIN_OFFSET_Q16 = 25'd17901158;
  localparam logic [16:0] T0_OFFSET_CK      = 17'd27315;
  localparam logic [21:0] BYTE_OFFSET_Q16   = 22'd2621440;

  // log2 in Q24: mantissa in Q30, one squaring per fraction bit
  localparam int FRAC_BITS = 24;
  localparam int MANT_BITS = 31;

  // temperature divider: quotient capped at 2^40
  localparam int TEMP_QW  = 41;
  localparam int TEMP_DW  = 38;
  localparam int TEMP_NW  = 63;

  typedef struct packed {
    logic abs_zero;
    logic hot;
  } ntc_flags_t;

endpackage

[rtl/ntc_adc_to_temperature_core.sv]
// NTC thermistor converter using the beta equation. Each ADC code from a
// pull-up divider gives one result: the thermistor resistance in ohms
// (rounded, saturated at 2^32-1), the temperature in 1/16 C (floored, at most
// 32767) and a byte holding temperature + 40 C in 1 K steps (truncated,
// clamped to 0..255). Codes of zero and full scale read as absolute zero.
// The pipeline takes one code every clock while the result side accepts; the
// depth comes from three 24-step squaring log2 units and a 41-stage radix-2
// divider. A stall on the result side freezes the whole pipeline. Registers are
// to be written over the APB port by the user only while no sample is in flight;
// the block does not enforce this. Derived constants follow through t0c, then bt.
module ntc_adc_to_temperature_core #(
  parameter int ADC_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0]      s_tdata,  // adc_code
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [55:0]                        m_tdata   // ntc_ohms, celsius_sixteenths,
                                                       // temp_code_m40
);
  import ntc_pkg::*;

  localparam int XW  = 20 + ADC_BITS;
  localparam int NBW = $clog2(XW);
  localparam int LGW = NBW + FRAC_BITS;
  localparam int LW  = LGW + 2;
  localparam int PW  = LW + 33;
  localparam int LNW = PW - 40;
  localparam int DPW = LNW + 17;
  localparam int DSW = DPW + 1;
  localparam int OQW = TEMP_QW;
  localparam int ONW = OQW + 1;
  localparam int NLOG = 3;
  localparam int TAGS = FRAC_BITS + 2; // L1, L2 and 24 squaring stages
  localparam int PST  = 5;
  localparam logic [ADC_BITS-1:0] FULL = '1;
  localparam logic [40:0] TEMP_CAP = 41'h100_0000_0000;

  // configuration registers
  logic [19:0]       ser;
  logic [19:0]       r0;
  logic [13:0]       beta;
  logic signed [8:0] nom;
  ntc_reg_t          idx;

  assign idx    = ntc_reg_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser  <= SERIES_RESET;
      r0   <= R0_RESET;
      beta <= BETA_RESET;
      nom  <= T0_RESET;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_SERIES: ser  <= pwdata[19:0];
        REG_R0:     r0   <= pwdata[19:0];
        REG_BETA:   beta <= pwdata[13:0];
        REG_T0:     nom  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SERIES: prdata = {12'd0, ser};
      REG_R0:     prdata = {12'd0, r0};
      REG_BETA:   prdata = {18'd0, beta};
      REG_T0:     prdata = {23'd0, nom};
      default:    prdata = '0;
    endcase
  end

  // constants derived from the registers
  logic [13:0]        beta_e;
  logic signed [16:0] t0c;
  logic [29:0]        bt;
  logic [20:0]        b100;

  assign beta_e = (beta == '0) ? 14'd1 : beta;

  always_ff @(posedge clk) begin
    t0c  <= 17'(nom) * 17'sd100 + $signed(T0_OFFSET_CK);
    bt   <= 30'(beta_e) * 30'(t0c[15:0]);
    b100 <= 21'(beta_e) * 21'd100;
  end

  // pipeline advance
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // front: capture, resistance numerator
  logic                v_f1, v_f2;
  logic [ADC_BITS-1:0] code_f1, dn_f2;
  logic [XW-1:0]       sc_f2;
  logic                az_f2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f1 <= 1'b0;
      v_f2 <= 1'b0;
    end else if (en) begin
      v_f1 <= s_tvalid;
      v_f2 <= v_f1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_f1 <= s_tdata[ADC_BITS-1:0];
      sc_f2   <= XW'(ser) * XW'(code_f1);
      dn_f2   <= FULL - code_f1;
      az_f2   <= (code_f1 == '0) || (code_f1 == FULL) || (ser == '0) || (r0 == '0);
    end
  end

  // sideband through the log units
  logic          tv  [TAGS];
  logic          taz [TAGS];
  logic [XW:0]   ton [TAGS];
  logic [ADC_BITS-1:0] tod [TAGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      tv[0] <= 1'b0;
    end else if (en) begin
      tv[0] <= v_f2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      taz[0] <= az_f2;
      ton[0] <= (XW+1)'(sc_f2) + (XW+1)'(dn_f2 >> 1);
      tod[0] <= dn_f2;
    end
  end

  for (genvar g = 1; g < TAGS; g++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) begin
        tv[g] <= 1'b0;
      end else if (en) begin
        tv[g] <= tv[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        taz[g] <= taz[g-1];
        ton[g] <= ton[g-1];
        tod[g] <= tod[g-1];
      end
    end
  end

  // log2 lanes: series*code, fullscale-code, nominal resistance
  logic [XW-1:0]          xin [NLOG];
  logic [XW-1:0]          lx  [NLOG];
  logic [NBW-1:0]         lnb [NLOG];
  logic [LGW-1:0]         lg  [NLOG];
  logic [MANT_BITS-1:0]   sm  [NLOG][FRAC_BITS+1];
  logic [FRAC_BITS-1:0]   sf  [NLOG][FRAC_BITS+1];
  logic [NBW-1:0]         sn  [NLOG][FRAC_BITS+1];

  assign xin[0] = sc_f2;
  assign xin[1] = XW'(dn_f2);
  assign xin[2] = XW'(r0);

  for (genvar k = 0; k < NLOG; k++) begin : g_log
    logic [NBW-1:0]  msb;
    logic [XW+29:0]  nsh;

    always_comb begin
      msb = '0;
      for (int i = 0; i < XW; i++) begin
        if (xin[k][i]) begin
          msb = NBW'(i);
        end
      end
    end

    assign nsh = {lx[k], 30'd0} >> lnb[k];

    always_ff @(posedge clk) begin
      if (en) begin
        lx[k]    <= xin[k];
        lnb[k]   <= msb;
        sm[k][0] <= nsh[MANT_BITS-1:0];
        sf[k][0] <= '0;
        sn[k][0] <= lnb[k];
      end
    end

    for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_sq
      logic [2*MANT_BITS-1:0] sq;
      logic [MANT_BITS:0]     sp;

      assign sq = (2*MANT_BITS)'(sm[k][j-1]) * (2*MANT_BITS)'(sm[k][j-1]);
      assign sp = sq[2*MANT_BITS-1:MANT_BITS-1];

      // renormalise when the square reaches two
      always_ff @(posedge clk) begin
        if (en) begin
          sm[k][j] <= sp[MANT_BITS] ? sp[MANT_BITS:1] : sp[MANT_BITS-1:0];
          sf[k][j] <= {sf[k][j-1][FRAC_BITS-2:0], sp[MANT_BITS]};
          sn[k][j] <= sn[k][j-1];
        end
      end
    end

    assign lg[k] = {sn[k][FRAC_BITS], sf[k][FRAC_BITS]};
  end

  // beta equation denominator and numerator
  logic                  pv  [PST];
  logic                  paz [PST];
  logic [XW:0]           pon [PST];
  logic [ADC_BITS-1:0]   pod [PST];
  logic signed [LW-1:0]  l_p1;
  logic signed [PW-1:0]  prod_p2;
  logic signed [DPW-1:0] dp_p3;
  logic signed [DSW-1:0] den_s, den_p4;
  logic                  hot_p4, hot_p5;
  logic [TEMP_DW-1:0]    tden_p5;
  logic [TEMP_NW-1:0]    numr_p5;

  assign den_s = $signed(DSW'({b100, 16'd0})) + DSW'(dp_p3);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (en) begin
      pv[0] <= tv[TAGS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      paz[0]  <= taz[TAGS-1];
      pon[0]  <= ton[TAGS-1];
      pod[0]  <= tod[TAGS-1];
      l_p1    <= $signed(LW'(lg[0])) - $signed(LW'(lg[1])) - $signed(LW'(lg[2]));
      prod_p2 <= PW'(l_p1) * $signed(PW'(LN2_Q32));
      dp_p3   <= DPW'(t0c) * DPW'($signed(prod_p2[PW-1:40]));
      den_p4  <= den_s;
      hot_p4  <= den_s[DSW-1] || (den_s == '0);
      hot_p5  <= hot_p4;
      tden_p5 <= den_p4[TEMP_DW-1:0];
      numr_p5 <= TEMP_NW'({bt, 32'd0}) + TEMP_NW'(den_p4[TEMP_DW-1:1]);
    end
  end

  for (genvar g = 1; g < PST; g++) begin : g_pst
    always_ff @(posedge clk) begin
      if (rst) begin
        pv[g] <= 1'b0;
      end else if (en) begin
        pv[g] <= pv[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        paz[g] <= paz[g-1];
        pon[g] <= pon[g-1];
        pod[g] <= pod[g-1];
      end
    end
  end

  // dividers: resistance and kelvin, same depth
  logic [OQW-1:0]     oq, tq;
  logic               oovf, tovf, ov;
  ntc_flags_t         tfl_in, tfl;

  assign tfl_in = '{abs_zero: paz[PST-1], hot: hot_p5};

  ntc_div #(
    .NW(ONW), .DW(ADC_BITS), .QW(OQW), .TAG_T(logic)
  ) u_ohm_div (
    .clk(clk), .rst(rst), .en(en),
    .num(ONW'(pon[PST-1])), .den(pod[PST-1]), .tag_in(pv[PST-1]),
    .quot(oq), .ovf(oovf), .tag_out(ov)
  );

  ntc_div #(
    .NW(TEMP_NW), .DW(TEMP_DW), .QW(TEMP_QW), .TAG_T(ntc_flags_t)
  ) u_temp_div (
    .clk(clk), .rst(rst), .en(en),
    .num(numr_p5), .den(tden_p5), .tag_in(tfl_in),
    .quot(tq), .ovf(tovf), .tag_out(tfl)
  );

  // output formatting
  logic [31:0]        ohms;
  logic [40:0]        tk;
  logic signed [42:0] cq, bv;
  logic signed [30:0] sx;
  logic [15:0]        sixteenths;
  logic [7:0]         tbyte;

  always_comb begin
    ohms = (oovf || (oq[OQW-1:32] != '0)) ? 32'hFFFF_FFFF : oq[31:0];
    tk   = (tovf || (tq > TEMP_CAP)) ? TEMP_CAP : tq;
    if (tfl.abs_zero) begin
      tk = '0;
    end
    cq = $signed(43'(tk)) - $signed(43'(KELVIN_OFFSET_Q16));
    sx = cq[42:12];
    bv = cq + $signed(43'(BYTE_OFFSET_Q16));
    sixteenths = (sx > 31'sd32767) ? 16'h7FFF : sx[15:0];
    if (bv[42]) begin
      tbyte = 8'd0;
    end else if (bv[42:16] > 27'd255) begin
      tbyte = 8'd255;
    end else begin
      tbyte = bv[23:16];
    end
    if (tfl.hot && !tfl.abs_zero) begin
      sixteenths = 16'h7FFF;
      tbyte      = 8'd255;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ov;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {tbyte, sixteenths, ohms};
    end
  end

endmodule

[rtl/ntc_div.sv]
module ntc_div #(
  parameter int NW = 42,
  parameter int DW = 12,
  parameter int QW = 41,
  parameter type TAG_T = logic
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  TAG_T          tag_in,
  output logic [QW-1:0] quot,
  output logic          ovf,
  output TAG_T          tag_out
);
  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] lo  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic          ov  [QW+1];
  TAG_T          tg  [QW+1];
  logic [CW-1:0] hi;

  assign hi = CW'(num[NW-1:QW]);

  // quotient does not fit when the top part already reaches the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= hi[DW-1:0];
      dv[0]  <= den;
      lo[0]  <= num[QW-1:0];
      q[0]   <= '0;
      ov[0]  <= (hi >= CW'(den));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tg[0] <= '0;
    end else if (en) begin
      tg[0] <= tag_in;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] d;
    logic        ge;

    assign t  = {rem[k-1], lo[k-1][QW-1]};
    assign d  = t - {1'b0, dv[k-1]};
    assign ge = ~d[DW];

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? d[DW-1:0] : t[DW-1:0];
        dv[k]  <= dv[k-1];
        lo[k]  <= lo[k-1] << 1;
        q[k]   <= {q[k-1][QW-2:0], ge};
        ov[k]  <= ov[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k] <= '0;
      end else if (en) begin
        tg[k] <= tg[k-1];
      end
    end
  end

  assign quot    = q[QW];
  assign ovf     = ov[QW];
  assign tag_out = tg[QW];

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import ntc_pkg::*;

  localparam int ADC_BITS = 12;
  localparam longint FULL = (64'd1 << ADC_BITS) - 1;
  localparam longint LN2_Q32_L = 64'd2977044472;
  localparam longint KOFF_Q16 = 64'd17901158;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic [7:0]  code_m40;
    logic [15:0] sixteenths;
    logic [31:0] ohms;
  } ntc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;

  // predictor's copy of the registers
  logic [19:0] series_q = SERIES_RESET;
  logic [19:0] r0_q = R0_RESET;
  logic [13:0] beta_q = BETA_RESET;
  logic [8:0]  t0_q = T0_RESET;

  logic [11:0] code_queue[$];
  ntc_result_t expected_results[$];
  int errors = 0;
  longint cycle = 0;
  bit hold_sender = 1'b0;
  int send_gap = 0;
  int stall_gap = 0;

  ntc_adc_to_temperature_core #(.ADC_BITS(ADC_BITS)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint log2_q24(longint unsigned x);
    int n;
    longint unsigned t, m, r;
    n = 0;
    t = x;
    while (t > 1) begin
      t >>= 1;
      n++;
    end
    m = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
    r = longint'(n) << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        r |= 64'd1 << i;
      end
    end
    return r;
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic ntc_result_t convert_code(logic [11:0] code_in);
    longint unsigned code, ser, r0, beta, ohms, q, tq16, num, ud;
    longint t0c, l, ln16, den, cq16, six, bval, v;
    bit abs_zero, hot;
    ntc_result_t res;
    code = code_in & FULL;
    ser = series_q;
    r0 = r0_q;
    beta = (beta_q == 0) ? 1 : beta_q;
    t0c = longint'($signed(t0_q)) * 100 + 27315;
    abs_zero = 0;
    hot = 0;
    tq16 = 0;
    if (code == FULL) ohms = 64'hFFFF_FFFF;
    else begin
      q = (ser * code + (FULL - code) / 2) / (FULL - code);
      ohms = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
    end
    if (code == 0 || code == FULL || ser == 0 || r0 == 0) abs_zero = 1;
    else begin
      l = log2_q24(ser * code) - log2_q24(FULL - code) - log2_q24(r0);
      ln16 = floor_div(l * LN2_Q32_L, 64'sd1 <<< 40);
      den = longint'(100 * beta * 65536) + t0c * ln16;
      if (den <= 0) hot = 1;
      else begin
        num = (beta * longint'(t0c)) << 32;
        ud = den;
        tq16 = (num + ud / 2) / ud;
        if (tq16 > (64'd1 << 40)) tq16 = 64'd1 << 40;
      end
    end
    if (hot) begin
      six = 32767;
      bval = 255;
    end else begin
      if (abs_zero) tq16 = 0;
      cq16 = longint'(tq16) - KOFF_Q16;
      six = floor_div(cq16, 4096);
      if (six > 32767) six = 32767;
      v = cq16 + 40 * 65536;
      if (v < 0) bval = 0;
      else begin
        bval = v / 65536;
        if (bval > 255) bval = 255;
      end
    end
    res.ohms = ohms[31:0];
    res.sixteenths = six[15:0];
    res.code_m40 = bval[7:0];
    return res;
  endfunction

  // sender: present one request at a time, random gap after each request
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(convert_code(s_tdata[11:0]));
        void'(code_queue.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // hold
      end else if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (code_queue.size() != 0 && !hold_sender) begin
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, code_queue[0]};
        send_gap <= $urandom_range(0, 17) * ($urandom_range(0, 3) == 0);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure, check every result in order
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result %h", $time, m_tdata);
          errors++;
        end else begin
          ntc_result_t exp_r, got;
          exp_r = expected_results.pop_front();
          got = m_tdata;
          if (got.ohms !== exp_r.ohms)
            $display("%0t ohms exp %0d got %0d", $time, exp_r.ohms, got.ohms);
          if (got.sixteenths !== exp_r.sixteenths)
            $display("%0t sixteenths exp %0d got %0d", $time,
                     $signed(exp_r.sixteenths), $signed(got.sixteenths));
          if (got.code_m40 !== exp_r.code_m40)
            $display("%0t byte exp %0d got %0d", $time, exp_r.code_m40, got.code_m40);
          if (got !== exp_r) errors++;
        end
      end
      if (stall_gap > 0) begin
        m_tready <= 1'b0;
        stall_gap <= stall_gap - 1;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_gap <= $urandom_range(0, 17);
      end
    end
    if (cycle > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(ntc_reg_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SERIES: series_q = val[19:0];
      REG_R0: r0_q = val[19:0];
      REG_BETA: beta_q = val[13:0];
      REG_T0: t0_q = val[8:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (code_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_codes(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: code_queue.push_back(12'($urandom_range(0, 15)));
        1: code_queue.push_back(12'($urandom_range(4080, 4095)));
        default: code_queue.push_back(12'($urandom_range(0, 4095)));
      endcase
    end
  endtask

  initial begin
    logic [11:0] directed[$];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    directed = '{12'd0, 12'd1, 12'd2, 12'd2047, 12'd2048, 12'd4094, 12'd4095,
                 12'hAAA, 12'h555, 12'd100, 12'd3000, 12'd4000};
    foreach (directed[i]) code_queue.push_back(directed[i]);
    drain();
    // extremes of every register, then random settings
    write_reg(REG_SERIES, 32'd1000000);
    write_reg(REG_R0, 32'd1);
    write_reg(REG_BETA, 32'd1000);
    write_reg(REG_T0, 32'h1D8); // -40 C
    foreach (directed[i]) code_queue.push_back(directed[i]);
    drain();
    write_reg(REG_SERIES, 32'd1);
    write_reg(REG_R0, 32'd1000000);
    write_reg(REG_BETA, 32'd10000);
    write_reg(REG_T0, 32'd150);
    foreach (directed[i]) code_queue.push_back(directed[i]);
    drain();
    write_reg(REG_SERIES, 32'd0);
    write_reg(REG_BETA, 32'd0);
    code_queue.push_back(12'd1234);
    drain();
    write_reg(REG_SERIES, 32'hFFFFF);
    write_reg(REG_R0, 32'd0);
    write_reg(REG_BETA, 32'h3FFF);
    write_reg(REG_T0, 32'h1FF);
    code_queue.push_back(12'd1234);
    code_queue.push_back(12'd4000);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_SERIES, $urandom_range(1, 1000000));
      write_reg(REG_R0, $urandom_range(1, 1000000));
      write_reg(REG_BETA, $urandom_range(1000, 10000));
      write_reg(REG_T0, $urandom_range(0, 190) - 40);
      random_codes(150);
      // let the pipeline empty once before resuming
      while (code_queue.size() > 75) @(posedge clk);
      hold_sender = 1'b1;
      while (expected_results.size() != 0 || s_tvalid) @(posedge clk);
      hold_sender = 1'b0;
      drain();
    end
    write_reg(REG_SERIES, SERIES_RESET);
    write_reg(REG_R0, R0_RESET);
    write_reg(REG_BETA, BETA_RESET);
    write_reg(REG_T0, T0_RESET);
    random_codes(850);
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/ntc_pkg.sv
rtl/ntc_div.sv
rtl/ntc_adc_to_temperature_core.sv
tb/tb_top.sv
